// ===== src/mm_pkg.sv =====
`default_nettype none

package mm_pkg;

  localparam int ELEM_W    = 16;
  localparam int PROD_W    = 2 * ELEM_W;
  localparam int SUM_W     = 36;
  localparam int DIM_W     = 4;
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 3;

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;
  typedef logic [DIM_W-1:0]         dim_t;
  typedef logic [POS_W-1:0]         pos_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS_A    = 2'd0,
    REG_INNER_DIM = 2'd1,
    REG_COLS_B    = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== src/mm_ram.sv =====
`default_nettype none

module mm_ram #(
  parameter int WIDTH  = 16,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/matrix_multiply.sv =====
`default_nettype none

// channel   ports                                            handshake
// input     in_element_value                                 start && !busy
// result    out_product_value, out_row, out_col,             out_valid, one cycle
//           out_result_last
// config    cfg_index, cfg_data                              cfg_we, no wait
//
// loading accepts an item if start is high and busy is low; the last B item
// raises busy for rows*inner*cols terms, one multiply-accumulate per cycle
// through the single shared multiplier and accumulator.
// reset (synchronous, rst_n low) sets all sizes to 1 and restarts loading.
// results come out one per inner-dimension pass; the receiver cannot stall.

module matrix_multiply #(
  parameter int MAX_DIM = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire mm_pkg::elem_t                 in_element_value,
  output logic                               out_valid,
  output mm_pkg::sum_t                       out_product_value,
  output mm_pkg::pos_t                       out_row,
  output mm_pkg::pos_t                       out_col,
  output logic                               out_result_last,
  input  wire logic                          cfg_we,
  input  wire logic [mm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire mm_pkg::dim_t                  cfg_data
);

  import mm_pkg::*;

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam dim_t MAXD = DIM_W'(MAX_DIM);

  typedef logic [IW-1:0] idx_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;

  dim_t rows_r, rows_nxt, inner_r, inner_nxt, cols_r, cols_nxt;
  dim_t rows_c, inner_c, cols_c;

  // load position: outer / inner counter, phase low for A, high for B
  idx_t ld_p_r, ld_p_nxt, ld_q_r, ld_q_nxt;
  logic ld_b_r, ld_b_nxt;

  idx_t ci_r, ci_nxt, cj_r, cj_nxt, ck_r, ck_nxt;

  logic s1_vld_r, s1_vld_nxt, s1_first_r, s1_klast_r, s1_final_r;
  idx_t s1_row_r, s1_col_r;
  logic s2_vld_r, s2_vld_nxt, s2_first_r, s2_klast_r, s2_final_r;
  idx_t s2_row_r, s2_col_r;
  prod_t prod_r;
  sum_t  sum_r, sum_nxt;

  logic out_valid_r, out_valid_nxt;
  sum_t out_product_r;
  pos_t out_row_r, out_col_r;
  logic out_last_r;

  logic accept, ld_done, p_end, q_end;
  logic k_end, j_end, i_end;
  logic [AW-1:0] waddr, raddr_a, raddr_b;
  logic [ELEM_W-1:0] rdata_a, rdata_b;

  function automatic dim_t clamp_dim(dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = dim_t'(1);
    end else if (v > MAXD) begin
      r = MAXD;
    end
    return r;
  endfunction

  always_comb begin
    rows_c  = clamp_dim(rows_r);
    inner_c = clamp_dim(inner_r);
    cols_c  = clamp_dim(cols_r);
  end

  assign busy   = (state_r != ST_LOAD);
  assign accept = start && !busy;

  assign p_end   = ld_b_r ? (DIM_W'(ld_p_r) == inner_c - 1'b1)
                          : (DIM_W'(ld_p_r) == rows_c - 1'b1);
  assign q_end   = ld_b_r ? (DIM_W'(ld_q_r) == cols_c - 1'b1)
                          : (DIM_W'(ld_q_r) == inner_c - 1'b1);
  assign ld_done = ld_b_r && p_end && q_end;

  assign k_end = (DIM_W'(ck_r) == inner_c - 1'b1);
  assign j_end = (DIM_W'(cj_r) == cols_c - 1'b1);
  assign i_end = (DIM_W'(ci_r) == rows_c - 1'b1);

  assign waddr   = AW'(int'(ld_p_r) * MAX_DIM + int'(ld_q_r));
  assign raddr_a = AW'(int'(ci_r) * MAX_DIM + int'(ck_r));
  assign raddr_b = AW'(int'(ck_r) * MAX_DIM + int'(cj_r));

  mm_ram #(
    .WIDTH  (ELEM_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_left_ram (
    .clk   (clk),
    .we    (accept && !ld_b_r),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  mm_ram #(
    .WIDTH  (ELEM_W),
    .DEPTH  (DEPTH),
    .ADDR_W (AW)
  ) u_right_ram (
    .clk   (clk),
    .we    (accept && ld_b_r),
    .waddr (waddr),
    .wdata (in_element_value),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  always_comb begin
    state_nxt  = state_r;
    rows_nxt   = rows_r;
    inner_nxt  = inner_r;
    cols_nxt   = cols_r;
    ld_p_nxt   = ld_p_r;
    ld_q_nxt   = ld_q_r;
    ld_b_nxt   = ld_b_r;
    ci_nxt     = ci_r;
    cj_nxt     = cj_r;
    ck_nxt     = ck_r;
    s1_vld_nxt = 1'b0;
    s2_vld_nxt = s1_vld_r;
    sum_nxt    = s2_first_r ? sum_t'(prod_r) : sum_r + sum_t'(prod_r);
    out_valid_nxt = s2_vld_r && s2_klast_r;

    // loading
    if (accept) begin
      if (q_end) begin
        ld_q_nxt = '0;
        if (p_end) begin
          ld_p_nxt = '0;
          ld_b_nxt = !ld_b_r;
        end else begin
          ld_p_nxt = ld_p_r + 1'b1;
        end
      end else begin
        ld_q_nxt = ld_q_r + 1'b1;
      end
    end

    case (state_r)
      ST_LOAD: begin
        if (accept && ld_done) begin
          state_nxt = ST_RUN;
          ci_nxt    = '0;
          cj_nxt    = '0;
          ck_nxt    = '0;
        end
      end
      ST_RUN: begin
        s1_vld_nxt = 1'b1;
        if (k_end) begin
          ck_nxt = '0;
          if (j_end) begin
            cj_nxt = '0;
            if (i_end) begin
              state_nxt = ST_DRAIN;
            end else begin
              ci_nxt = ci_r + 1'b1;
            end
          end else begin
            cj_nxt = cj_r + 1'b1;
          end
        end else begin
          ck_nxt = ck_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (s2_vld_r && s2_final_r) begin
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // a size write restarts loading
    if (cfg_we) begin
      case (cfg_index)
        REG_ROWS_A: begin
          rows_nxt = cfg_data;
          ld_p_nxt = '0;
          ld_q_nxt = '0;
          ld_b_nxt = 1'b0;
        end
        REG_INNER_DIM: begin
          inner_nxt = cfg_data;
          ld_p_nxt  = '0;
          ld_q_nxt  = '0;
          ld_b_nxt  = 1'b0;
        end
        REG_COLS_B: begin
          cols_nxt = cfg_data;
          ld_p_nxt = '0;
          ld_q_nxt = '0;
          ld_b_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    s1_first_r <= (ck_r == '0);
    s1_klast_r <= k_end;
    s1_final_r <= k_end && j_end && i_end;
    s1_row_r   <= ci_r;
    s1_col_r   <= cj_r;
    s2_first_r <= s1_first_r;
    s2_klast_r <= s1_klast_r;
    s2_final_r <= s1_final_r;
    s2_row_r   <= s1_row_r;
    s2_col_r   <= s1_col_r;
    prod_r     <= $signed(rdata_a) * $signed(rdata_b);
    if (s2_vld_r) begin
      sum_r <= sum_nxt;
    end
    if (s2_vld_r && s2_klast_r) begin
      out_product_r <= sum_nxt;
      out_row_r     <= POS_W'(s2_row_r);
      out_col_r     <= POS_W'(s2_col_r);
      out_last_r    <= s2_final_r;
    end
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      rows_r      <= dim_t'(1);
      inner_r     <= dim_t'(1);
      cols_r      <= dim_t'(1);
      ld_p_r      <= '0;
      ld_q_r      <= '0;
      ld_b_r      <= 1'b0;
      ci_r        <= '0;
      cj_r        <= '0;
      ck_r        <= '0;
      s1_vld_r    <= 1'b0;
      s2_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      inner_r     <= inner_nxt;
      cols_r      <= cols_nxt;
      ld_p_r      <= ld_p_nxt;
      ld_q_r      <= ld_q_nxt;
      ld_b_r      <= ld_b_nxt;
      ci_r        <= ci_nxt;
      cj_r        <= cj_nxt;
      ck_r        <= ck_nxt;
      s1_vld_r    <= s1_vld_nxt;
      s2_vld_r    <= s2_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_product_value = out_product_r;
  assign out_row           = out_row_r;
  assign out_col           = out_col_r;
  assign out_result_last   = out_last_r;

  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a compute pass");

  a_quiet_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_last) |=> !out_valid)
    else $error("result after the final element");

  a_pipe_empty_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LOAD) |-> (!s1_vld_r && !s2_vld_r))
    else $error("multiply pipeline active while loading");

  a_drain_no_issue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> !s2_vld_r || $past(s1_vld_r))
    else $error("pipeline stage without an issued term");

endmodule

`default_nettype wire
